### hw/rtl/spre_pkg.sv
package spre_pkg;

  localparam int NODE_W          = 9;
  localparam int DIST_W          = 48;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 9;
  localparam int DEF_MAX_NODES   = 256;
  localparam int DEF_MAX_EDGES   = 1024;
  localparam int DEF_WEIGHT_BITS = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'b1;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUERY,
    S_INIT,
    S_EDGE_RD,
    S_DIST_RD,
    S_RELAX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic edge_wr;
    logic edge_rd;
    logic dist_rd;
    logic query_rd;
    logic init_run;
    logic relax_en;
    logic check;
    logic out_status;
    logic out_query;
  } cmd_t;

  typedef struct packed {
    logic relax_hit;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/spre_ctrl.sv
module spre_ctrl
  import spre_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic                        in_last_edge,
  input  logic [$clog2(MAX_NODES+1)-1:0] round_lim,
  input  sts_t                        sts,
  output cmd_t                        cmd,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_addr
);

  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  state_t              state_r, state_nxt;
  logic [ECNT_W-1:0]   total_r, total_nxt;
  logic [ECNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]    r_r, r_nxt;
  logic                chk_r, chk_nxt;
  logic [ECNT_W-1:0]   k_inc;
  logic [CNT_W-1:0]    r_inc;
  logic                store_full;

  assign k_inc      = k_r + ECNT_W'(1);
  assign r_inc      = r_r + CNT_W'(1);
  assign store_full = (total_r == ECNT_W'(MAX_EDGES));

  assign edge_addr = (state_r == S_IDLE || state_r == S_QUERY) ?
                     total_r[EDGE_AW-1:0] : k_r[EDGE_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      k_r     <= '0;
      r_r     <= '0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      k_r     <= k_nxt;
      r_r     <= r_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    k_nxt     = k_r;
    r_nxt     = r_r;
    chk_nxt   = chk_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE, S_QUERY: begin
        if (state_r == S_QUERY) begin
          // pending answer goes out as soon as the output register frees up
          in_ready      = sts.out_free;
          cmd.out_query = sts.out_free;
          if (sts.out_free) state_nxt = S_IDLE;
        end else begin
          in_ready = 1'b1;
        end
        if (in_valid && in_ready) begin
          if (in_func == FUNC_QUERY) begin
            cmd.query_rd = 1'b1;
            state_nxt    = S_QUERY;
          end else begin
            if (!store_full) begin
              cmd.edge_wr = 1'b1;
              total_nxt   = total_r + ECNT_W'(1);
            end
            if (in_last_edge) state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init_run = 1'b1;
        k_nxt        = '0;
        r_nxt        = '0;
        chk_nxt      = 1'b0;
        state_nxt    = (total_r == '0) ? S_DONE : S_EDGE_RD;
      end
      S_EDGE_RD: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_DIST_RD;
      end
      S_DIST_RD: begin
        cmd.dist_rd = 1'b1;
        state_nxt   = S_RELAX;
      end
      S_RELAX: begin
        cmd.relax_en = 1'b1;
        cmd.check    = chk_r;
        if (chk_r && sts.relax_hit) begin
          state_nxt = S_DONE;
        end else if (k_inc < total_r) begin
          k_nxt     = k_inc;
          state_nxt = S_EDGE_RD;
        end else if (chk_r) begin
          state_nxt = S_DONE;
        end else if (r_inc < round_lim) begin
          r_nxt     = r_inc;
          k_nxt     = '0;
          state_nxt = S_EDGE_RD;
        end else begin
          // all rounds done: one more sweep looking for a relaxable edge
          chk_nxt   = 1'b1;
          k_nxt     = '0;
          state_nxt = S_EDGE_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_status = 1'b1;
          total_nxt      = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= ECNT_W'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE_RD) |-> (k_r < total_r))
    else $error("edge read past stored edges");

  a_relax_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELAX) |-> ($past(state_r) == S_DIST_RD))
    else $error("relax step without distance read");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && sts.out_free) |=> (total_r == '0 && state_r == S_IDLE))
    else $error("edge store not emptied after run");

endmodule

### hw/rtl/spre_datapath.sv
module spre_datapath
  import spre_pkg::*;
#(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int MAX_EDGES   = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic [NODE_W-1:0]             in_edge_from,
  input  logic [NODE_W-1:0]             in_edge_to,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  input  logic [NODE_W-1:0]             in_query_node,
  input  cmd_t                          cmd,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_addr,
  output sts_t                          sts,
  output logic [$clog2(MAX_NODES+1)-1:0] round_lim,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic signed [DIST_W-1:0]      out_distance,
  output logic                          out_reachable,
  output logic                          out_negative_cycle
);

  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int CMP_W   = (CNT_W > NODE_W) ? CNT_W : NODE_W;
  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int EDGE_DW = 2 * NODE_W + WEIGHT_BITS;
  localparam int SUM_W   = DIST_W + 1;

  function automatic logic node_ok(input logic [NODE_W-1:0] node,
                                   input logic [CNT_W-1:0]  lim);
    return (node != '0) && (CMP_W'(node) <= CMP_W'(lim));
  endfunction

  function automatic logic [NODE_AW-1:0] node_idx(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] m1;
    m1 = node - NODE_W'(1);
    return NODE_AW'(m1);
  endfunction

  logic [CFG_DATA_W-1:0] node_count_r;
  logic [CFG_DATA_W-1:0] source_node_r;
  logic [CNT_W-1:0]      n_eff;

  logic [EDGE_DW-1:0]    edge_mem [MAX_EDGES];
  logic [EDGE_DW-1:0]    edge_rd_r;
  logic [DIST_W-1:0]     dist_mem [MAX_NODES];
  logic [DIST_W-1:0]     rd_a_r;
  logic [DIST_W-1:0]     rd_b_r;
  logic [MAX_NODES-1:0]  reached_r;
  logic                  cycle_r;
  logic                  q_ok_r;

  logic [NODE_W-1:0]            e_from, e_to;
  logic signed [WEIGHT_BITS-1:0] e_w;
  logic                         a_ok, b_ok;
  logic [NODE_AW-1:0]           a_idx, b_idx, q_idx, src_idx;
  logic                         src_ok;
  logic signed [SUM_W-1:0]      cand, old_b;
  logic signed [DIST_W-1:0]     cand_sat;
  logic                         hit;
  logic                         dist_we;
  logic [NODE_AW-1:0]           dist_wa;
  logic [DIST_W-1:0]            dist_wd;
  logic                         out_valid_r;
  logic                         out_kind_r, out_reach_r, out_neg_r;
  logic [DIST_W-1:0]            out_dist_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= CFG_DATA_W'(1);
      source_node_r <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_COUNT:  node_count_r  <= cfg_data;
        REG_SOURCE_NODE: source_node_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (node_count_r == '0)
      n_eff = CNT_W'(1);
    else if (CMP_W'(node_count_r) > CMP_W'(MAX_NODES))
      n_eff = CNT_W'(MAX_NODES);
    else
      n_eff = CNT_W'(node_count_r);
  end
  assign round_lim = n_eff;

  // edge store
  always_ff @(posedge clk) begin
    if (cmd.edge_wr) edge_mem[edge_addr] <= {in_edge_from, in_edge_to, in_edge_weight};
    if (cmd.edge_rd) edge_rd_r <= edge_mem[edge_addr];
  end

  assign e_from = edge_rd_r[EDGE_DW-1 -: NODE_W];
  assign e_to   = edge_rd_r[WEIGHT_BITS+NODE_W-1 -: NODE_W];
  assign e_w    = edge_rd_r[WEIGHT_BITS-1:0];

  assign a_ok    = node_ok(e_from, n_eff);
  assign b_ok    = node_ok(e_to, n_eff);
  assign a_idx   = node_idx(e_from);
  assign b_idx   = node_idx(e_to);
  assign q_idx   = node_idx(in_query_node);
  assign src_ok  = node_ok(source_node_r, n_eff);
  assign src_idx = node_idx(source_node_r);

  // exact sum, one bit wider than a stored distance
  assign cand  = {rd_a_r[DIST_W-1], rd_a_r} +
                 {{(SUM_W-WEIGHT_BITS){e_w[WEIGHT_BITS-1]}}, e_w};
  assign old_b = {rd_b_r[DIST_W-1], rd_b_r};
  assign hit   = a_ok && b_ok && reached_r[a_idx] && (!reached_r[b_idx] || cand < old_b);

  always_comb begin
    if (cand[SUM_W-1] != cand[DIST_W-1])
      cand_sat = cand[SUM_W-1] ? DIST_MIN : DIST_MAX;
    else
      cand_sat = cand[DIST_W-1:0];
  end

  assign dist_we = (cmd.init_run && src_ok) || (cmd.relax_en && !cmd.check && hit);
  assign dist_wa = cmd.init_run ? src_idx : b_idx;
  assign dist_wd = cmd.init_run ? '0 : cand_sat;

  // node distances: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (cmd.dist_rd) begin
      rd_a_r <= dist_mem[a_idx];
      rd_b_r <= dist_mem[b_idx];
    end else if (cmd.query_rd) begin
      rd_a_r <= dist_mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= '0;
      cycle_r   <= 1'b0;
    end else if (cmd.init_run) begin
      // only the source starts reached
      reached_r <= src_ok ? (MAX_NODES'(1) << src_idx) : '0;
      cycle_r   <= 1'b0;
    end else if (cmd.relax_en && hit) begin
      if (cmd.check) cycle_r <= 1'b1;
      else reached_r[b_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_rd)
      q_ok_r <= node_ok(in_query_node, n_eff) && reached_r[q_idx];
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_status || cmd.out_query) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_status) begin
      out_kind_r  <= KIND_STATUS;
      out_dist_r  <= '0;
      out_reach_r <= 1'b0;
      out_neg_r   <= cycle_r;
    end else if (cmd.out_query) begin
      out_kind_r  <= KIND_QUERY;
      out_dist_r  <= q_ok_r ? rd_a_r : '0;
      out_reach_r <= q_ok_r;
      out_neg_r   <= cycle_r;
    end
  end

  assign sts.relax_hit = hit;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_distance       = out_dist_r;
  assign out_reachable      = out_reach_r;
  assign out_negative_cycle = out_neg_r;

endmodule

### hw/rtl/shortest_path_relaxation_engine_top.sv
// Edge loads, queries: one word per cycle; a word after a query waits for a free
// output register, which then takes the answer read from distance memory. Last edge
// starts a run over E stored edges, N active nodes: init, N rounds, a checking sweep
// up to the first relaxable edge; each edge takes edge read, distance read, relax/write.
// Synchronous active-low reset: no stored edges, all nodes unreached, no cycle
// flag, node_count and source_node at 1; memories are not cleared.
module shortest_path_relaxation_engine_top
  import spre_pkg::*;
#(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int MAX_EDGES   = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [NODE_W-1:0]             in_edge_from,
  input  logic [NODE_W-1:0]             in_edge_to,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  input  logic                          in_last_edge,
  input  logic [NODE_W-1:0]             in_query_node,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic signed [DIST_W-1:0]      out_distance,
  output logic                          out_reachable,
  output logic                          out_negative_cycle
);

  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  cmd_t               cmd;
  sts_t               sts;
  logic [CNT_W-1:0]   round_lim;
  logic [EDGE_AW-1:0] edge_addr;

  spre_ctrl #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_last_edge (in_last_edge),
    .round_lim    (round_lim),
    .sts          (sts),
    .cmd          (cmd),
    .edge_addr    (edge_addr)
  );

  spre_datapath #(
    .MAX_NODES   (MAX_NODES),
    .MAX_EDGES   (MAX_EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_edge_from       (in_edge_from),
    .in_edge_to         (in_edge_to),
    .in_edge_weight     (in_edge_weight),
    .in_query_node      (in_query_node),
    .cmd                (cmd),
    .edge_addr          (edge_addr),
    .sts                (sts),
    .round_lim          (round_lim),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_distance       (out_distance),
    .out_reachable      (out_reachable),
    .out_negative_cycle (out_negative_cycle)
  );

endmodule
